[rtl/envelope_follower_adaptive_threshold_core_assert.svh]
// ----------------------------------------------------------------------------
// envelope follower assertion macros
// clocked assertion wrappers, with and without a reset qualifier
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_FOLLOWER_ADAPTIVE_THRESHOLD_CORE_ASSERT_SVH
`define ENVELOPE_FOLLOWER_ADAPTIVE_THRESHOLD_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define EFAT_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("efat assertion failed");
`define EFAT_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("efat assertion failed");
`else
`define EFAT_ASSERT(label, clk, rst_n, prop)
`define EFAT_ASSERT_NR(label, clk, prop)
`endif

`endif

[rtl/efat_pkg.sv]
// ----------------------------------------------------------------------------
// efat_pkg
// widths, reset values, register codes and stage types of the envelope follower
// ----------------------------------------------------------------------------
package efat_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned LevelW  = 31;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_WEIGHT    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd1;

  localparam logic [LevelW-1:0] MinReset    = 31'd80000000;
  localparam logic [CfgW-1:0]   WeightReset = 16'd655;
  localparam logic [CfgW-1:0]   ThrReset    = 16'd32768;

  // rectified sample on its way to the tracker
  typedef struct packed {
    logic              valid;
    logic              clear;
    logic [LevelW-1:0] mag;
  } efat_mag_t;

  // tracker state on its way to the compare stage
  typedef struct packed {
    logic              valid;
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] floor_level;
    logic [LevelW-1:0] peak_level;
  } efat_state_t;

endpackage

[rtl/efat_if.sv]
// ----------------------------------------------------------------------------
// efat_if
// sample and result channels with valid/ready transfer
// ----------------------------------------------------------------------------
interface efat_in_if
  import efat_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] sample;
  logic                      clear_peak;

  modport source (output valid, sample, clear_peak, input ready);
  modport sink (input valid, sample, clear_peak, output ready);
endinterface

interface efat_out_if
  import efat_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [LevelW-1:0] level;
  logic [LevelW-1:0] floor_level;
  logic [LevelW-1:0] peak_level;
  logic              above;

  modport source (output valid, level, floor_level, peak_level, above, input ready);
  modport sink (input valid, level, floor_level, peak_level, above, output ready);
endinterface

[rtl/efat_front.sv]
// ----------------------------------------------------------------------------
// efat_front
// input register with full-wave rectifier, most negative sample saturates
// ----------------------------------------------------------------------------
module efat_front
  import efat_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      clear_i,
  output logic                      ready_o,
  input  logic                      ready_i,
  output efat_mag_t                 mag_o
);

  logic              valid_q;
  logic              clear_q;
  logic [LevelW-1:0] mag_q;
  logic [LevelW-1:0] mag_d;
  logic [SampleW-1:0] neg;
  logic              adv;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;
  assign neg     = ~sample_i + 1'b1;

  always_comb begin
    if (sample_i[SampleW-1] && (sample_i[SampleW-2:0] == '0)) begin
      mag_d = '1;
    end else if (sample_i[SampleW-1]) begin
      mag_d = neg[LevelW-1:0];
    end else begin
      mag_d = sample_i[LevelW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && valid_i) begin
      mag_q   <= mag_d;
      clear_q <= clear_i;
    end
  end

  assign mag_o = '{valid: valid_q, clear: clear_q, mag: mag_q};

endmodule

[rtl/efat_track.sv]
// ----------------------------------------------------------------------------
// efat_track
// q16 moving average of the magnitude with running minimum and maximum
// ----------------------------------------------------------------------------
module efat_track
  import efat_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  efat_mag_t       mag_i,
  input  logic [CfgW-1:0] weight_i,
  output logic            ready_o,
  input  logic            ready_i,
  output efat_state_t     st_o
);

  localparam int unsigned DiffW = LevelW + 1;
  localparam int unsigned ProdW = DiffW + CfgW + 1;

  logic              valid_q;
  logic [LevelW-1:0] env_q, env_d;
  logic [LevelW-1:0] min_q, min_d;
  logic [LevelW-1:0] max_q, max_d;
  logic [LevelW-1:0] max_base;
  logic signed [DiffW-1:0] diff;
  logic signed [CfgW:0]    wext;
  logic signed [ProdW-1:0] prod;
  logic signed [ProdW-1:0] sum;
  logic adv;
  logic take;

  assign adv     = !valid_q || ready_i;
  assign take    = adv && mag_i.valid;
  assign ready_o = adv;

  // env + round((mag - env) * w / 2^16), same as the weighted sum of both
  assign diff  = $signed({1'b0, mag_i.mag}) - $signed({1'b0, env_q});
  assign wext  = $signed({1'b0, weight_i});
  assign prod  = diff * wext;
  assign sum   = prod + $signed({{(ProdW-CfgW){1'b0}}, 16'h8000});
  assign env_d = env_q + sum[CfgW +: LevelW];

  assign max_base = mag_i.clear ? '0 : max_q;
  assign max_d    = (env_d > max_base) ? env_d : max_base;
  assign min_d    = (env_d < min_q) ? env_d : min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      env_q   <= '0;
      min_q   <= MinReset;
      max_q   <= '0;
    end else begin
      if (adv) begin
        valid_q <= mag_i.valid;
      end
      if (take) begin
        env_q <= env_d;
        min_q <= min_d;
        max_q <= max_d;
      end
    end
  end

  assign st_o = '{valid: valid_q, level: env_q, floor_level: min_q, peak_level: max_q};

endmodule

[rtl/efat_cmp.sv]
// ----------------------------------------------------------------------------
// efat_cmp
// threshold compare against the min-to-max span and result register
// ----------------------------------------------------------------------------
module efat_cmp
  import efat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  efat_state_t       st_i,
  input  logic [CfgW-1:0]   thr_i,
  output logic              ready_o,
  input  logic              ready_i,
  output logic              valid_o,
  output logic [LevelW-1:0] level_o,
  output logic [LevelW-1:0] floor_o,
  output logic [LevelW-1:0] peak_o,
  output logic              above_o
);

  localparam int unsigned CmpW = LevelW + CfgW;

  logic              valid_q;
  logic [LevelW-1:0] level_q, floor_q, peak_q;
  logic              above_q, above_d;
  logic [LevelW-1:0] span, num;
  logic [CmpW-1:0]   lhs, rhs;
  logic adv;

  assign adv     = !valid_q || ready_i;
  assign ready_o = adv;

  assign span = st_i.peak_level - st_i.floor_level;
  assign num  = st_i.level - st_i.floor_level;
  assign lhs  = {num, {CfgW{1'b0}}};
  assign rhs  = thr_i * span;

  assign above_d = (st_i.peak_level > st_i.floor_level) &&
                   (st_i.level >= st_i.floor_level) && (lhs > rhs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= st_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && st_i.valid) begin
      level_q <= st_i.level;
      floor_q <= st_i.floor_level;
      peak_q  <= st_i.peak_level;
      above_q <= above_d;
    end
  end

  assign valid_o = valid_q;
  assign level_o = level_q;
  assign floor_o = floor_q;
  assign peak_o  = peak_q;
  assign above_o = above_q;

endmodule

[rtl/envelope_follower_adaptive_threshold_core.sv]
// path: a transferred sample is registered in the input register, then the envelope register, then the result register
// throughput: one sample per cycle while the receiver is ready, set by the envelope update loop
//   (one 32 x 17 multiply-add feeding back into the envelope register)
// each stage holds its item while the next stage is full and stalled, bubbles are filled on the fly
// reset: asynchronous, envelope and maximum cleared, minimum to 80000000,
//   weight 655, threshold 32768, pipeline empty
// ----------------------------------------------------------------------------
// envelope_follower_adaptive_threshold_core
// rectified q16 envelope with running floor and peak and a span-relative threshold
// ----------------------------------------------------------------------------
`include "envelope_follower_adaptive_threshold_core_assert.svh"

module envelope_follower_adaptive_threshold_core
  import efat_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  efat_in_if.sink            in_i,
  efat_out_if.source         out_o
);

  logic [CfgW-1:0] weight_q;
  logic [CfgW-1:0] thr_q;

  efat_mag_t   mag;
  efat_state_t st;
  logic        track_ready;
  logic        cmp_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= WeightReset;
      thr_q    <= ThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WEIGHT:    weight_q <= cfg_data_i;
        REG_THRESHOLD: thr_q    <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  efat_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_i.valid),
    .sample_i (in_i.sample),
    .clear_i  (in_i.clear_peak),
    .ready_o  (in_i.ready),
    .ready_i  (track_ready),
    .mag_o    (mag)
  );

  efat_track u_track (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .mag_i    (mag),
    .weight_i (weight_q),
    .ready_o  (track_ready),
    .ready_i  (cmp_ready),
    .st_o     (st)
  );

  efat_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .st_i    (st),
    .thr_i   (thr_q),
    .ready_o (cmp_ready),
    .ready_i (out_o.ready),
    .valid_o (out_o.valid),
    .level_o (out_o.level),
    .floor_o (out_o.floor_level),
    .peak_o  (out_o.peak_level),
    .above_o (out_o.above)
  );

  `EFAT_ASSERT(a_order, clk_i, rst_ni, out_o.valid |-> (out_o.floor_level <= out_o.level) && (out_o.level <= out_o.peak_level))
  `EFAT_ASSERT(a_above_span, clk_i, rst_ni, (out_o.valid && out_o.above) |-> (out_o.peak_level > out_o.floor_level))
  `EFAT_ASSERT(a_empty_ready, clk_i, rst_ni, !out_o.valid |-> in_i.ready)
  `EFAT_ASSERT_NR(a_rst_empty, clk_i, !rst_ni |-> !out_o.valid)

endmodule

[bench/tb_envelope_follower_adaptive_threshold_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_envelope_follower_adaptive_threshold_core
// Drives rectified-envelope samples through the valid/ready channels. A local
// tracker predicts the level, floor, peak and threshold flag for each
// accepted sample, and every result transfer is checked against it in order.
// Directed cases cover the register extremes, sign saturation, a held
// envelope, a zero span and a long receiver hold-off. Random phases follow
// with new register settings and random gaps on both sides.
// ----------------------------------------------------------------------------
module tb_envelope_follower_adaptive_threshold_core;
  import efat_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned PhaseItems    = 100;

  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 2'd3;

  localparam logic signed [SampleW-1:0] MostNegative = {1'b1, {(SampleW-1){1'b0}}};
  localparam logic signed [SampleW-1:0] SampleMax    = {1'b0, {(SampleW-1){1'b1}}};

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [LevelW-1:0] floor_level;
    logic [LevelW-1:0] peak_level;
    logic              above;
  } envelope_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]    cfg_data;

  efat_in_if  in_ch ();
  efat_out_if out_ch ();

  envelope_result_t  pending_levels[$];
  int unsigned       mismatches;
  int unsigned       in_idle_pct;
  int unsigned       out_idle_pct;
  int unsigned       hold_cycles;

  // tracker state
  logic [LevelW-1:0] trk_envelope;
  logic [LevelW-1:0] trk_floor;
  logic [LevelW-1:0] trk_peak;
  logic [CfgW-1:0]   cfg_weight;
  logic [CfgW-1:0]   cfg_thresh;

  envelope_follower_adaptive_threshold_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic envelope_result_t follow_envelope(logic signed [SampleW-1:0] smp,
                                                       logic clr);
    logic [LevelW-1:0] mag;
    logic [63:0]       acc;
    logic [63:0]       lhs;
    logic [63:0]       rhs;
    envelope_result_t  res;
    if (smp == MostNegative) begin
      mag = '1;
    end else if (smp[SampleW-1]) begin
      mag = LevelW'(~smp + 1);
    end else begin
      mag = smp[LevelW-1:0];
    end
    if (clr) begin
      trk_peak = '0;
    end
    acc = 64'(mag) * 64'(cfg_weight)
        + 64'(trk_envelope) * (64'd65536 - 64'(cfg_weight)) + 64'd32768;
    trk_envelope = acc[LevelW+15:16];
    if (trk_envelope > trk_peak) begin
      trk_peak = trk_envelope;
    end
    if (trk_envelope < trk_floor) begin
      trk_floor = trk_envelope;
    end
    res.above = 1'b0;
    if (trk_peak > trk_floor && trk_envelope >= trk_floor) begin
      lhs = 64'(trk_envelope - trk_floor) << 16;
      rhs = 64'(cfg_thresh) * 64'(trk_peak - trk_floor);
      res.above = lhs > rhs;
    end
    res.level       = trk_envelope;
    res.floor_level = trk_floor;
    res.peak_level  = trk_peak;
    return res;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  function automatic logic signed [SampleW-1:0] random_sample(int unsigned shift);
    logic signed [SampleW-1:0] raw;
    raw = $urandom;
    case ($urandom_range(0, 15))
      0: return MostNegative;
      1: return SampleMax;
      2: return '0;
      3: return -1;
      default: return raw >>> shift;
    endcase
  endfunction

  function automatic void compare_field(string name, logic [LevelW-1:0] want,
                                        logic [LevelW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic push_sample(input logic signed [SampleW-1:0] smp, input logic clr);
    int unsigned gap;
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.sample     <= smp;
    in_ch.clear_peak <= clr;
    do @(posedge clk); while (!in_ch.ready);
    pending_levels.push_back(follow_envelope(smp, clr));
    gap = ($urandom_range(0, 99) < in_idle_pct) ? pick_gap() : 0;
    if (gap != 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      REG_WEIGHT:    cfg_weight = data;
      REG_THRESHOLD: cfg_thresh = data;
      default: ;
    endcase
  endtask

  // unused indexes must leave both registers alone
  task automatic configure(input logic [CfgW-1:0] weight, input logic [CfgW-1:0] thresh);
    write_reg(REG_WEIGHT, weight);
    write_reg(REG_THRESHOLD, thresh);
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CfgW'($urandom));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    in_idle_pct  = 30;
    out_idle_pct = 30;
    push_sample(MostNegative, 1'b0);
    push_sample(SampleMax, 1'b0);
    push_sample('0, 1'b0);
    push_sample(-1, 1'b1);
    push_sample(1, 1'b0);
    drain_results();
  endtask

  task automatic test_zero_weight();
    configure('0, ThrReset);
    push_sample(SampleMax, 1'b0);
    push_sample(MostNegative, 1'b1);
    push_sample(-1, 1'b0);
    drain_results();
  endtask

  task automatic test_threshold_extremes();
    configure('1, '0);
    push_sample(SampleMax, 1'b0);
    push_sample(1, 1'b0);
    push_sample('0, 1'b0);
    drain_results();
    configure('1, '1);
    push_sample(SampleMax, 1'b0);
    push_sample(MostNegative + 1, 1'b1);
    push_sample('0, 1'b1);
    drain_results();
  endtask

  // envelope and floor settle at zero, then a peak clear leaves no span
  task automatic test_zero_span();
    configure('1, ThrReset);
    push_sample('0, 1'b0);
    push_sample('0, 1'b0);
    push_sample('0, 1'b1);
    push_sample('0, 1'b0);
    drain_results();
  endtask

  task automatic test_backpressure();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    hold_cycles  = 60;
    repeat (24) push_sample(random_sample($urandom_range(0, 30)), $urandom_range(0, 7) == 0);
    drain_results();
  endtask

  task automatic test_random_phases();
    int unsigned     shift;
    logic [CfgW-1:0] weight;
    logic [CfgW-1:0] thresh;
    shift = 0;
    for (int p = 0; p < 8; p++) begin
      weight = CfgW'($urandom);
      thresh = CfgW'($urandom);
      case (p)
        0: begin
          weight = '1;
          thresh = '0;
        end
        1: begin
          weight = 16'd1;
          thresh = '1;
        end
        3: begin
          weight = WeightReset;
          thresh = ThrReset;
        end
        7: weight = 16'd4096;
        default: ;
      endcase
      configure(weight, thresh);
      if (p == 2 || p == 5) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end else begin
        in_idle_pct  = $urandom_range(10, 60);
        out_idle_pct = $urandom_range(10, 60);
      end
      // loud and quiet stretches so the flag moves both ways
      for (int k = 0; k < PhaseItems; k++) begin
        if (k % 16 == 0) begin
          shift = $urandom_range(0, 30);
        end
        push_sample(random_sample(shift), $urandom_range(0, 19) == 0);
      end
      drain_results();
    end
  endtask

  always @(posedge clk) begin : result_check
    envelope_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_levels.size() == 0) begin
        $error("result transfer with no sample pending");
        mismatches++;
      end else begin
        want = pending_levels.pop_front();
        compare_field("level", want.level, out_ch.level);
        compare_field("floor_level", want.floor_level, out_ch.floor_level);
        compare_field("peak_level", want.peak_level, out_ch.peak_level);
        compare_field("above", LevelW'(want.above), LevelW'(out_ch.above));
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_cycles != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_cycles - 1) @(negedge clk);
        hold_cycles = 0;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < out_idle_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchdogLimit) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb_envelope_follower_adaptive_threshold_core failed");
    $finish;
  end

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_idx          = '0;
    cfg_data         = '0;
    in_ch.valid      = 1'b0;
    in_ch.sample     = '0;
    in_ch.clear_peak = 1'b0;
    out_ch.ready     = 1'b0;
    mismatches       = 0;
    in_idle_pct      = 0;
    out_idle_pct     = 0;
    hold_cycles      = 0;
    trk_envelope     = '0;
    trk_floor        = MinReset;
    trk_peak         = '0;
    cfg_weight       = WeightReset;
    cfg_thresh       = ThrReset;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_zero_weight();
    test_threshold_extremes();
    test_zero_span();
    test_backpressure();
    test_random_phases();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_envelope_follower_adaptive_threshold_core passed");
    end else begin
      $display("tb_envelope_follower_adaptive_threshold_core failed");
    end
    $finish;
  end

endmodule
